### src/ads_pkg.sv
// Shared types and constants of the anti-aliased dot splatter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ads_pkg;

    localparam int COORD_W   = 24;
    localparam int COLOR_W   = 16;
    localparam int PIX_W     = 12;
    localparam int INC_W     = 18;
    localparam int DIM_W     = 13;
    localparam int WEIGHT_W  = 16;
    // Signed width for coordinate and bound arithmetic; covers a 24-bit
    // coordinate and an image edge up to 65536.
    localparam int CALC_W    = 26;

    localparam int DEF_MAX_WIDTH       = 4096;
    localparam int DEF_MAX_HEIGHT      = 4096;
    localparam int DEF_COORD_FRAC_BITS = 8;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANTIALIAS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAGONAL_WEIGHT = 3'd4;

    localparam logic [DIM_W-1:0] RST_IMAGE_DIM = 13'd4096;

    typedef struct packed {
        logic signed [COORD_W-1:0] dot_x;
        logic signed [COORD_W-1:0] dot_y;
        logic [COLOR_W-1:0]        color;
    } t_dot;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic [INC_W-1:0] increment;
        logic             last;
    } t_pix;

    typedef struct packed {
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
        logic                antialias;
        logic [WEIGHT_W-1:0] straight_weight;
        logic [WEIGHT_W-1:0] diagonal_weight;
    } t_cfg;

    // One classified dot: where its writes go, which groups of writes it has,
    // and every share and spread term the writes are summed from.
    typedef struct packed {
        logic                aa;
        logic                emit_main;
        logic                emit_spread;
        logic [PIX_W-1:0]    x;
        logic [PIX_W-1:0]    y;
        logic [COLOR_W-1:0]  sh_a;
        logic [COLOR_W-1:0]  sh_b;
        logic [COLOR_W-1:0]  sh_c;
        logic [COLOR_W-1:0]  sh_d;
        logic [COLOR_W-1:0]  s_a;
        logic [COLOR_W-1:0]  s_b;
        logic [COLOR_W-1:0]  s_c;
        logic [COLOR_W-1:0]  s_d;
        logic [COLOR_W-1:0]  t_a;
        logic [COLOR_W-1:0]  t_b;
        logic [COLOR_W-1:0]  t_c;
        logic [COLOR_W-1:0]  t_d;
    } t_job;

endpackage

`default_nettype wire

### src/ads_front.sv
// Front end of the dot splatter: decodes each dot, checks it against the
// image bounds and works out all shares and spread terms in four stages.
// Depends on ads_pkg.
`default_nettype none

module ads_front #(
    parameter int MAX_WIDTH       = ads_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = ads_pkg::DEF_MAX_HEIGHT,
    parameter int COORD_FRAC_BITS = ads_pkg::DEF_COORD_FRAC_BITS
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  ads_pkg::t_cfg     i_cfg,
    input  wire               i_dot_valid,
    output logic              o_dot_ready,
    input  ads_pkg::t_dot     i_dot,
    output logic              o_job_valid,
    input  wire               i_job_ready,
    output ads_pkg::t_job     o_job
);

    localparam int CW       = ads_pkg::CALC_W;
    localparam int CN       = ads_pkg::COLOR_W;
    localparam int MAG_W    = ads_pkg::COORD_W + 1;
    localparam int FRAC_PAD = 16 - COORD_FRAC_BITS;
    localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (COORD_FRAC_BITS - 1);
    localparam logic signed [CW-1:0] ONE_S = 1;
    localparam logic [CN:0] WEIGHT_ONE = {1'b1, {CN{1'b0}}};

    logic en;

    // ---------------- stage 1: decode and fraction product ----------------
    logic signed [CW-1:0] x_floor, y_floor;
    logic [MAG_W-1:0]     x_mag, y_mag, x_rnd, y_rnd;
    logic [CN-1:0]        x_frac, y_frac;
    logic [2*CN-1:0]      fxy;

    always_comb begin
        x_floor = CW'($signed(i_dot.dot_x) >>> COORD_FRAC_BITS);
        y_floor = CW'($signed(i_dot.dot_y) >>> COORD_FRAC_BITS);
        x_mag = i_dot.dot_x[ads_pkg::COORD_W-1]
              ? (MAG_W'(0) - {i_dot.dot_x[ads_pkg::COORD_W-1], i_dot.dot_x})
              : {1'b0, i_dot.dot_x};
        y_mag = i_dot.dot_y[ads_pkg::COORD_W-1]
              ? (MAG_W'(0) - {i_dot.dot_y[ads_pkg::COORD_W-1], i_dot.dot_y})
              : {1'b0, i_dot.dot_y};
        x_rnd  = (x_mag + HALF) >> COORD_FRAC_BITS;
        y_rnd  = (y_mag + HALF) >> COORD_FRAC_BITS;
        x_frac = CN'(i_dot.dot_x[COORD_FRAC_BITS-1:0]) << FRAC_PAD;
        y_frac = CN'(i_dot.dot_y[COORD_FRAC_BITS-1:0]) << FRAC_PAD;
        fxy    = (2*CN)'(x_frac) * (2*CN)'(y_frac);
    end

    logic                 r1_v, r1_aa, r1_nx, r1_ny;
    logic signed [CW-1:0] r1_px, r1_py;
    logic [CN-1:0]        r1_fx, r1_fy, r1_d, r1_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_dot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_aa    <= i_cfg.antialias;
            r1_px    <= i_cfg.antialias ? x_floor : CW'(x_rnd);
            r1_py    <= i_cfg.antialias ? y_floor : CW'(y_rnd);
            r1_nx    <= !i_cfg.antialias && i_dot.dot_x[ads_pkg::COORD_W-1];
            r1_ny    <= !i_cfg.antialias && i_dot.dot_y[ads_pkg::COORD_W-1];
            r1_fx    <= x_frac;
            r1_fy    <= y_frac;
            r1_d     <= fxy[2*CN-1:CN];
            r1_color <= i_dot.color;
        end
    end

    // ---------------- stage 2: bounds and bilinear weights ----------------
    logic signed [CW-1:0] x2, y2, wi, hi, k_s;
    logic                 main_in, spread_in;
    logic [CN:0]          wa, wb, wc, wd;

    always_comb begin
        x2 = r1_nx ? -r1_px : r1_px;
        y2 = r1_ny ? -r1_py : r1_py;
        wi = (int'(i_cfg.image_width) > MAX_WIDTH) ? CW'(MAX_WIDTH)
                                                     : CW'(i_cfg.image_width);
        hi = (int'(i_cfg.image_height) > MAX_HEIGHT) ? CW'(MAX_HEIGHT)
                                                       : CW'(i_cfg.image_height);
        // The bilinear splat covers one pixel more to the right and below.
        k_s = r1_aa ? ONE_S : CW'(0);
        main_in = !x2[CW-1] && (x2 < wi - k_s)
               && !y2[CW-1] && (y2 < hi - k_s);
        spread_in = (i_cfg.straight_weight != '0)
                 && !x2[CW-1] && (x2 != '0) && (x2 < wi - k_s - ONE_S)
                 && !y2[CW-1] && (y2 != '0) && (y2 < hi - k_s - ONE_S);
        if (r1_aa) begin
            wa = WEIGHT_ONE - (CN+1)'(r1_fx) - (CN+1)'(r1_fy) + (CN+1)'(r1_d);
            wb = (CN+1)'(r1_fx) - (CN+1)'(r1_d);
            wc = (CN+1)'(r1_fy) - (CN+1)'(r1_d);
            wd = (CN+1)'(r1_d);
        end else begin
            // Rounded mode: the full color goes to the centre pixel.
            wa = WEIGHT_ONE;
            wb = '0;
            wc = '0;
            wd = '0;
        end
    end

    logic                       r2_v, r2_aa, r2_main, r2_spread;
    logic [ads_pkg::PIX_W-1:0]  r2_x, r2_y;
    logic [CN:0]                r2_wa, r2_wb, r2_wc, r2_wd;
    logic [CN-1:0]              r2_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_aa     <= r1_aa;
            r2_main   <= main_in;
            r2_spread <= spread_in;
            r2_x      <= x2[ads_pkg::PIX_W-1:0];
            r2_y      <= y2[ads_pkg::PIX_W-1:0];
            r2_wa     <= wa;
            r2_wb     <= wb;
            r2_wc     <= wc;
            r2_wd     <= wd;
            r2_color  <= r1_color;
        end
    end

    // ---------------- stage 3: shares of the color ----------------
    logic [2*CN:0] pa, pb, pc, pd;

    always_comb begin
        pa = (2*CN+1)'(r2_wa) * (2*CN+1)'(r2_color);
        pb = (2*CN+1)'(r2_wb) * (2*CN+1)'(r2_color);
        pc = (2*CN+1)'(r2_wc) * (2*CN+1)'(r2_color);
        pd = (2*CN+1)'(r2_wd) * (2*CN+1)'(r2_color);
    end

    logic                      r3_v, r3_aa, r3_main, r3_spread;
    logic [ads_pkg::PIX_W-1:0] r3_x, r3_y;
    logic [CN-1:0]             r3_a, r3_b, r3_c, r3_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_aa     <= r2_aa;
            r3_main   <= r2_main;
            r3_spread <= r2_spread;
            r3_x      <= r2_x;
            r3_y      <= r2_y;
            r3_a      <= pa[2*CN-1:CN];
            r3_b      <= pb[2*CN-1:CN];
            r3_c      <= pc[2*CN-1:CN];
            r3_d      <= pd[2*CN-1:CN];
        end
    end

    // ---------------- stage 4: spread terms ----------------
    logic [2*CN-1:0] psa, psb, psc, psd, pta, ptb, ptc, ptd;

    always_comb begin
        psa = (2*CN)'(i_cfg.diagonal_weight) * (2*CN)'(r3_a);
        psb = (2*CN)'(i_cfg.diagonal_weight) * (2*CN)'(r3_b);
        psc = (2*CN)'(i_cfg.diagonal_weight) * (2*CN)'(r3_c);
        psd = (2*CN)'(i_cfg.diagonal_weight) * (2*CN)'(r3_d);
        pta = (2*CN)'(i_cfg.straight_weight) * (2*CN)'(r3_a);
        ptb = (2*CN)'(i_cfg.straight_weight) * (2*CN)'(r3_b);
        ptc = (2*CN)'(i_cfg.straight_weight) * (2*CN)'(r3_c);
        ptd = (2*CN)'(i_cfg.straight_weight) * (2*CN)'(r3_d);
    end

    logic          r4_v;
    ads_pkg::t_job r4_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_job.aa          <= r3_aa;
            r4_job.emit_main   <= r3_main;
            r4_job.emit_spread <= r3_spread;
            r4_job.x           <= r3_x;
            r4_job.y           <= r3_y;
            r4_job.sh_a        <= r3_a;
            r4_job.sh_b        <= r3_b;
            r4_job.sh_c        <= r3_c;
            r4_job.sh_d        <= r3_d;
            r4_job.s_a         <= psa[2*CN-1:CN];
            r4_job.s_b         <= psb[2*CN-1:CN];
            r4_job.s_c         <= psc[2*CN-1:CN];
            r4_job.s_d         <= psd[2*CN-1:CN];
            r4_job.t_a         <= pta[2*CN-1:CN];
            r4_job.t_b         <= ptb[2*CN-1:CN];
            r4_job.t_c         <= ptc[2*CN-1:CN];
            r4_job.t_d         <= ptd[2*CN-1:CN];
        end
    end

    // A dot with no write in bounds is dropped here and never queued.
    assign o_job_valid = r4_v && (r4_job.emit_main || r4_job.emit_spread);
    assign o_job       = r4_job;
    assign en          = !(o_job_valid && !i_job_ready);
    assign o_dot_ready = en;

endmodule

`default_nettype wire

### src/ads_queue.sv
// Short queue of classified dots between the front and back ends.
// Depends on ads_pkg for the entry type and depth.
`default_nettype none

module ads_queue #(
    parameter int DEPTH = ads_pkg::QUEUE_DEPTH
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push_valid,
    output logic           o_push_ready,
    input  ads_pkg::t_job  i_push_data,
    output logic           o_pop_valid,
    input  wire            i_pop_ready,
    output ads_pkg::t_job  o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ads_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;
    assign o_pop_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### src/ads_back.sv
// Back end of the dot splatter: walks through the writes of one queued dot,
// one write per cycle while the output is not stalled, into a registered output.
// Depends on ads_pkg.
`default_nettype none

module ads_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_job_valid,
    output logic           o_job_ready,
    input  ads_pkg::t_job  i_job,
    output logic           o_pix_valid,
    input  wire            i_pix_ready,
    output ads_pkg::t_pix  o_pix
);

    localparam int PW = ads_pkg::PIX_W;
    localparam int CN = ads_pkg::COLOR_W;
    localparam int IW = ads_pkg::INC_W;

    localparam logic PH_MAIN   = 1'b0;
    localparam logic PH_SPREAD = 1'b1;

    localparam logic [PW-1:0] OFS_M1 = {PW{1'b1}};
    localparam logic [PW-1:0] OFS_0  = '0;
    localparam logic [PW-1:0] OFS_P1 = PW'(1);

    logic          r_busy, r_phase;
    logic [3:0]    r_idx;
    ads_pkg::t_job r_job;
    logic          r_out_valid;
    ads_pkg::t_pix r_out;

    logic          gen, is_last, end_main, pop;
    logic [PW-1:0] dx, dy;
    logic [CN-1:0] t1, t2, t3;
    ads_pkg::t_pix nxt;

    always_comb begin
        dx = OFS_0;
        dy = OFS_0;
        t1 = '0;
        t2 = '0;
        t3 = '0;
        if (r_phase == PH_MAIN) begin
            if (r_job.aa) begin
                dx = PW'(r_idx[0]);
                dy = PW'(r_idx[1]);
                case (r_idx[1:0])
                    2'd0:    t1 = r_job.sh_a;
                    2'd1:    t1 = r_job.sh_b;
                    2'd2:    t1 = r_job.sh_c;
                    default: t1 = r_job.sh_d;
                endcase
            end else begin
                t1 = r_job.sh_a;
            end
        end else if (r_job.aa) begin
            // 4x4 block from one pixel up and left of the dot, row by row.
            dx = PW'(r_idx[1:0]) - OFS_P1;
            dy = PW'(r_idx[3:2]) - OFS_P1;
            case (r_idx)
                4'd0:  t1 = r_job.s_a;
                4'd1:  begin t1 = r_job.t_a; t2 = r_job.s_b; end
                4'd2:  begin t1 = r_job.t_b; t2 = r_job.s_a; end
                4'd3:  t1 = r_job.s_b;
                4'd4:  begin t1 = r_job.t_a; t2 = r_job.s_c; end
                4'd5:  begin t1 = r_job.s_d; t2 = r_job.t_b; t3 = r_job.t_c; end
                4'd6:  begin t1 = r_job.s_c; t2 = r_job.t_a; t3 = r_job.t_d; end
                4'd7:  begin t1 = r_job.t_b; t2 = r_job.s_d; end
                4'd8:  begin t1 = r_job.t_c; t2 = r_job.s_a; end
                4'd9:  begin t1 = r_job.s_b; t2 = r_job.t_a; t3 = r_job.t_d; end
                4'd10: begin t1 = r_job.s_a; t2 = r_job.t_b; t3 = r_job.t_c; end
                4'd11: begin t1 = r_job.t_d; t2 = r_job.s_b; end
                4'd12: t1 = r_job.s_c;
                4'd13: begin t1 = r_job.t_c; t2 = r_job.s_d; end
                4'd14: begin t1 = r_job.t_d; t2 = r_job.s_c; end
                default: t1 = r_job.s_d;
            endcase
        end else begin
            // Eight neighbours of the rounded pixel, centre skipped.
            case (r_idx[2:0])
                3'd0:    begin dx = OFS_M1; dy = OFS_M1; t1 = r_job.s_a; end
                3'd1:    begin dx = OFS_0;  dy = OFS_M1; t1 = r_job.t_a; end
                3'd2:    begin dx = OFS_P1; dy = OFS_M1; t1 = r_job.s_a; end
                3'd3:    begin dx = OFS_M1; dy = OFS_0;  t1 = r_job.t_a; end
                3'd4:    begin dx = OFS_P1; dy = OFS_0;  t1 = r_job.t_a; end
                3'd5:    begin dx = OFS_M1; dy = OFS_P1; t1 = r_job.s_a; end
                3'd6:    begin dx = OFS_0;  dy = OFS_P1; t1 = r_job.t_a; end
                default: begin dx = OFS_P1; dy = OFS_P1; t1 = r_job.s_a; end
            endcase
        end
    end

    always_comb begin
        end_main = r_job.aa ? (r_idx == 4'd3) : 1'b1;
        if (r_phase == PH_MAIN) begin
            is_last = end_main && !r_job.emit_spread;
        end else begin
            is_last = r_job.aa ? (r_idx == 4'd15) : (r_idx == 4'd7);
        end
        nxt.pixel_x   = r_job.x + dx;
        nxt.pixel_y   = r_job.y + dy;
        nxt.increment = IW'(t1) + IW'(t2) + IW'(t3);
        nxt.last      = is_last;
    end

    assign gen         = r_busy && (!r_out_valid || i_pix_ready);
    assign o_job_ready = !r_busy || (gen && is_last);
    assign pop         = i_job_valid && o_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= PH_MAIN;
            r_idx   <= '0;
        end else if (pop) begin
            r_busy  <= 1'b1;
            r_phase <= i_job.emit_main ? PH_MAIN : PH_SPREAD;
            r_idx   <= '0;
        end else if (gen) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else if (r_phase == PH_MAIN && end_main) begin
                r_phase <= PH_SPREAD;
                r_idx   <= '0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (gen) begin
            r_out_valid <= 1'b1;
        end else if (i_pix_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen) begin
            r_out <= nxt;
        end
    end

    assign o_pix_valid = r_out_valid;
    assign o_pix       = r_out;

    a_main_has_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_phase == PH_MAIN) |-> r_job.emit_main)
        else $error("main writes walked for a dot without them");

    a_spread_has_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_phase == PH_SPREAD) |-> r_job.emit_spread)
        else $error("spread writes walked for a dot without them");

    a_main_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_phase == PH_MAIN) |-> (r_job.aa ? (r_idx < 4'd4) : (r_idx == 4'd0)))
        else $error("main write index out of range");

    a_rounded_spread_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_phase == PH_SPREAD && !r_job.aa) |-> (r_idx < 4'd8))
        else $error("rounded-mode spread index out of range");

endmodule

`default_nettype wire

### src/antialiased_dot_splatter.sv
// Anti-aliased dot splatter, top level: configuration registers, front end,
// queue and back end. Depends on ads_pkg, ads_front, ads_queue and ads_back.
//
// Usage: each dot item (dot_x, dot_y in signed fixed point, color) enters on
// the i_dot channel; the block answers with 0 to 20 pixel accumulate items on
// the o_pix channel, the final one of each dot marked by last. Dots whose
// writes all fall outside the image give no item at all.
// Configuration registers (index 0 width, 1 height, 2 antialias, 3 straight
// weight, 4 diagonal weight) are written on the cfg channel, which is always
// ready; they should change only while the block is idle.
// The first write of a dot passes through the four front stages, the queue,
// the back-end job register and the output register. Throughput is set by
// the single output port: one write per cycle while the receiver is ready.
// The front end takes a dot every cycle until the queue is full.
// When the receiver stalls, the output register holds its item, the back end
// stops, the queue fills and then i_dot is held off. Reset clears all control
// state and loads the register reset values (4096 x 4096, antialias on,
// weights zero).
`default_nettype none

module antialiased_dot_splatter #(
    parameter int MAX_WIDTH       = ads_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = ads_pkg::DEF_MAX_HEIGHT,
    parameter int COORD_FRAC_BITS = ads_pkg::DEF_COORD_FRAC_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [ads_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [ads_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                               i_dot_valid,
    output logic                              o_dot_ready,
    input  ads_pkg::t_dot                     i_dot,
    output logic                              o_pix_valid,
    input  wire                               i_pix_ready,
    output ads_pkg::t_pix                     o_pix
);

    ads_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width     <= ads_pkg::RST_IMAGE_DIM;
            r_cfg.image_height    <= ads_pkg::RST_IMAGE_DIM;
            r_cfg.antialias       <= 1'b1;
            r_cfg.straight_weight <= '0;
            r_cfg.diagonal_weight <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ads_pkg::CFG_IMAGE_WIDTH:
                    r_cfg.image_width <= i_cfg_data[ads_pkg::DIM_W-1:0];
                ads_pkg::CFG_IMAGE_HEIGHT:
                    r_cfg.image_height <= i_cfg_data[ads_pkg::DIM_W-1:0];
                ads_pkg::CFG_ANTIALIAS:
                    r_cfg.antialias <= i_cfg_data[0];
                ads_pkg::CFG_STRAIGHT_WEIGHT:
                    r_cfg.straight_weight <= i_cfg_data[ads_pkg::WEIGHT_W-1:0];
                ads_pkg::CFG_DIAGONAL_WEIGHT:
                    r_cfg.diagonal_weight <= i_cfg_data[ads_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    logic          fq_valid, fq_ready, qb_valid, qb_ready;
    ads_pkg::t_job fq_job, qb_job;

    ads_front #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_dot_valid (i_dot_valid),
        .o_dot_ready (o_dot_ready),
        .i_dot       (i_dot),
        .o_job_valid (fq_valid),
        .i_job_ready (fq_ready),
        .o_job       (fq_job)
    );

    ads_queue #(
        .DEPTH (ads_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_data  (fq_job),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_data   (qb_job)
    );

    ads_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (qb_valid),
        .o_job_ready (qb_ready),
        .i_job       (qb_job),
        .o_pix_valid (o_pix_valid),
        .i_pix_ready (i_pix_ready),
        .o_pix       (o_pix)
    );

endmodule

`default_nettype wire
